[hw/rtl/jse_pkg.sv]
// shared types, constants and helpers for the json string escaper
package jse_pkg;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_A       = 8'h61;
  localparam logic [15:0] BUF_SIZE_RESET = 16'd256;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_ESC,
    OP_UNI,
    OP_TERM
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  src;
    logic [15:0] pos;
    logic        wr;
    logic        trunc;
  } cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'b0, v};
    end else begin
      r = CH_A + {4'b0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

[hw/rtl/jse_in_if.sv]
// input byte channel
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[hw/rtl/jse_out_if.sv]
// escaped output byte channel
interface jse_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [15:0] out_pos;
  logic        write_valid;
  logic        run_last;
  logic        string_done;
  logic [15:0] total_length;
  logic        truncated;

  modport source (output valid, output out_byte, output out_pos, output write_valid,
                  output run_last, output string_done, output total_length,
                  output truncated, input ready);
  modport sink (input valid, input out_byte, input out_pos, input write_valid,
                input run_last, input string_done, input total_length,
                input truncated, output ready);
endinterface

[hw/rtl/jse_front.sv]
// front end: accepts source bytes, tracks fill level, classifies into commands
module jse_front import jse_pkg::*; #(
  parameter int SIZE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        q_full,
  output logic        push,
  output cmd_t        cmd
);

  logic [15:0]          buffer_size;
  logic [SIZE_BITS-1:0] used_count, used_count_next;
  logic                 stopped, stopped_next;

  logic                 accept;
  logic [31:0]          size32, used32;
  logic [SIZE_BITS:0]   size_eff, need;
  logic [2:0]           n;
  op_t                  op;
  logic                 is_zero;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign size32   = {16'b0, buffer_size};
  assign size_eff = {1'b0, size32[SIZE_BITS-1:0]};
  assign used32   = 32'(used_count);
  assign is_zero  = (in_byte == 8'h00);

  always_comb begin
    if (in_byte == CH_QUOTE || in_byte == CH_BSLASH) begin
      op = OP_ESC;
      n  = 3'd2;
    end else if (in_byte < CTRL_LIMIT) begin
      op = OP_UNI;
      n  = 3'd6;
    end else begin
      op = OP_CHAR;
      n  = 3'd1;
    end
  end

  // room needed for the replacement plus the terminator
  assign need = {1'b0, used_count} + (SIZE_BITS+1)'(n) + (SIZE_BITS+1)'(1);

  always_comb begin
    used_count_next = used_count;
    stopped_next    = stopped;
    push            = 1'b0;
    cmd.op          = op;
    cmd.src         = in_byte;
    cmd.pos         = used32[15:0];
    cmd.wr          = 1'b1;
    cmd.trunc       = 1'b0;
    if (accept) begin
      if (stopped) begin
        if (is_zero) begin
          stopped_next    = 1'b0;
          used_count_next = '0;
        end
      end else if (size_eff == '0) begin
        if (is_zero) begin
          push            = 1'b1;
          cmd.op          = OP_TERM;
          cmd.pos         = '0;
          cmd.wr          = 1'b0;
          used_count_next = '0;
        end
      end else if (is_zero) begin
        push            = 1'b1;
        cmd.op          = OP_TERM;
        used_count_next = '0;
      end else if (need > size_eff) begin
        push         = 1'b1;
        cmd.op       = OP_TERM;
        cmd.trunc    = 1'b1;
        stopped_next = 1'b1;
      end else begin
        push            = 1'b1;
        used_count_next = used_count + SIZE_BITS'(n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUF_SIZE_RESET;
      used_count  <= '0;
      stopped     <= 1'b0;
    end else begin
      if (cfg_we) begin
        buffer_size <= cfg_wdata;
      end
      used_count <= used_count_next;
      stopped    <= stopped_next;
    end
  end

`ifndef SYNTHESIS
  a_stopped_no_push: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !push) else $error("command issued while dropping");
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (push && cmd.op == OP_TERM && !cmd.trunc) |=> used_count == '0)
    else $error("fill level not cleared after terminator");
  a_trunc_stops: assert property (@(posedge clk) disable iff (rst)
    (push && cmd.trunc) |=> stopped) else $error("truncation did not stop");
`endif

endmodule

[hw/rtl/jse_queue.sv]
// small command queue between front and back
module jse_queue import jse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty)) else $error("pop from empty queue");
`endif

endmodule

[hw/rtl/jse_back.sv]
// back end: expands commands into escaped bytes through an output register
module jse_back import jse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      empty,
  input  cmd_t      head,
  output logic      pop,
  jse_out_if.source out_ch
);

  logic [2:0]  idx;
  logic        load, take, last;
  logic [7:0]  byte_sel;

  assign load = !out_ch.valid || out_ch.ready;
  assign take = load && !empty;
  assign pop  = take && last;

  always_comb begin
    last     = 1'b1;
    byte_sel = head.src;
    case (head.op)
      OP_CHAR: begin
        byte_sel = head.src;
      end
      OP_ESC: begin
        last     = (idx == 3'd1);
        byte_sel = (idx == 3'd0) ? CH_BSLASH : head.src;
      end
      OP_UNI: begin
        last = (idx == 3'd5);
        case (idx)
          3'd0:    byte_sel = CH_BSLASH;
          3'd1:    byte_sel = CH_U;
          3'd2:    byte_sel = CH_ZERO;
          3'd3:    byte_sel = CH_ZERO;
          3'd4:    byte_sel = hex_digit(head.src[7:4]);
          3'd5:    byte_sel = hex_digit(head.src[3:0]);
          default: byte_sel = 8'h00;
        endcase
      end
      OP_TERM: begin
        byte_sel = 8'h00;
      end
      default: begin
        byte_sel = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      out_ch.valid <= !empty;
      if (take) begin
        idx <= last ? 3'd0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.out_byte     <= byte_sel;
      out_ch.out_pos      <= head.pos + {13'b0, idx};
      out_ch.write_valid  <= head.wr;
      out_ch.run_last     <= last;
      out_ch.string_done  <= (head.op == OP_TERM);
      out_ch.total_length <= (head.op == OP_TERM) ? head.pos : 16'h0000;
      out_ch.truncated    <= (head.op == OP_TERM) && head.trunc;
    end
  end

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= 3'd5) else $error("run index out of range");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.string_done) |-> out_ch.run_last)
    else $error("terminator not last of run");
  a_nowrite_done: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.write_valid) |-> out_ch.string_done)
    else $error("unwritten byte that is not a terminator");
`endif

endmodule

[hw/rtl/json_string_escaper.sv]
// json string escaper top level
//
// in_ch carries one source byte per item; a zero byte ends the string.
// out_ch carries one escaped byte per item with its buffer position and
// the string end, length and truncation flags. cfg_we writes cfg_wdata
// into the buffer size register (bytes including the terminator).
// The front accepts one byte per cycle while the four-entry command
// queue has room. The back expands each command at one output item per
// cycle while the receiver is ready: two for a quote or backslash, six
// for a control byte, so those runs set the sustained rate.
// An accepted byte passes through the command queue and the output
// register before its first result is valid.
// Bytes dropped after truncation, or while the size is zero, give no
// output; with the size zero, a zero byte still gives an unwritten terminator.
// Reset (rst, synchronous) sets the buffer size to 256, clears the fill
// level and the drop state and empties the queue; no clearing pass.
// When the receiver stalls, the output register holds its item, the
// queue fills and in_ch.ready drops once the queue is full.
module json_string_escaper import jse_pkg::*; #(
  parameter int SIZE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  jse_in_if.sink      in_ch,
  jse_out_if.source   out_ch
);

  logic push, pop, q_full, q_empty;
  cmd_t push_cmd, head;

  jse_front #(.SIZE_BITS(SIZE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.in_byte),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  jse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  jse_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (q_empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
